// ===== rtl/hrtid_pkg.sv =====
// Package for the stream-real to binary64 converter.
// Holds field widths and bias constants; no dependencies.
`timescale 1ns / 1ps
package hrtid_pkg;
  localparam int unsigned FracW   = 56;
  localparam int unsigned LeadW   = 6;
  localparam int unsigned ExpW    = 11;
  localparam int unsigned MantW   = 52;
  // Biased exponent of the leading bit: lead + 4*hexexp - 312 + 1023
  localparam logic [ExpW-1:0] ExpOffset = 11'd711;
endpackage

// ===== rtl/hex_real_to_ieee_double.sv =====
// Top level of the stream-real to IEEE 754 double converter.
// Uses hrtid_pkg for widths and the exponent offset.
//
//  channel  | ports                          | direction
//  input    | start_i, busy_o, raw_real_i    | in
//  result   | valid_o, double_bits_o         | out
//
// Four register stages: leading-one search, normalize shift, round, pack.
// The result strobe follows the transfer through these stage registers; one item
// may enter every cycle, so busy_o stays low.
// Reset clears the stage valid bits only; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module hex_real_to_ieee_double (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] raw_real_i,
  output logic        valid_o,
  output logic [63:0] double_bits_o
);
  logic v1_q, v2_q, v3_q, v4_q;
  logic s1_q, s2_q, s3_q, s4_q;
  logic z1_q, z2_q, z3_q;
  logic [hrtid_pkg::FracW-1:0] f1_q;
  logic [hrtid_pkg::LeadW-1:0] lead_d, lead1_q;
  logic [hrtid_pkg::ExpW-1:0] e1_d, e1_q, e2_q, e3_d, e3_q;
  logic [hrtid_pkg::FracW-1:0] n2_d, n2_q;
  logic [53:0] m3_d, m3_q;
  logic [63:0] r4_d, r4_q;
  logic        lsb, grd, stk, up;
  logic [53:0] sum;

  assign busy_o = 1'b0;
  wire accept = start_i & ~busy_o;

  // Find the leading one of the fraction
  always_comb begin
    lead_d = '0;
    for (int k = 0; k < hrtid_pkg::FracW; k++) begin
      if (raw_real_i[k]) lead_d = hrtid_pkg::LeadW'(k);
    end
    e1_d = hrtid_pkg::ExpOffset + {2'b0, raw_real_i[62:56], 2'b0};
  end

  // Shift the leading one to the top of a 56-bit word
  always_comb begin
    n2_d = f1_q << (6'd55 - lead1_q);
  end

  // Round 53 bits to nearest even; carry out raises the exponent
  always_comb begin
    lsb = n2_q[3];
    grd = n2_q[2];
    stk = |n2_q[1:0];
    up  = grd & (stk | lsb);
    sum = {1'b0, n2_q[55:3]} + 54'(up);
    if (sum[53]) begin
      m3_d = sum >> 1;
      e3_d = e2_q + 11'd1;
    end else begin
      m3_d = sum;
      e3_d = e2_q;
    end
  end

  // Pack sign, exponent and mantissa; a zero fraction packs a signed zero
  always_comb begin
    if (z3_q) r4_d = {s3_q, 63'b0};
    else      r4_d = {s3_q, e3_q, m3_q[hrtid_pkg::MantW-1:0]};
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else begin
      v1_q <= accept; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    s1_q <= raw_real_i[63];
    z1_q <= ~|raw_real_i[55:0];
    f1_q <= raw_real_i[55:0];
    lead1_q <= lead_d;
    e1_q <= e1_d;
    s2_q <= s1_q; z2_q <= z1_q; n2_q <= n2_d;
    e2_q <= e1_q + {5'b0, lead1_q};
    s3_q <= s2_q; z3_q <= z2_q; m3_q <= m3_d; e3_q <= e3_d;
    s4_q <= s3_q; r4_q <= r4_d;
  end

  assign valid_o = v4_q;
  assign double_bits_o = r4_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##4 valid_o) else $error("result strobe missing");
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> double_bits_o[63] == s4_q) else $error("sign mismatch");
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !z3_q) |-> m3_q[52]) else $error("mantissa not normalized");
`endif
endmodule

// ===== verif/hex_real_to_ieee_double_test.sv =====
// Testbench for the stream-real to IEEE 754 double converter.
// Predicts each binary64 pattern in a local conversion function and checks
// every strobed result against it in order; depends on the RTL only.
`timescale 1ns / 1ps
module hex_real_to_ieee_double_test;

  localparam int unsigned IdleLimit = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [63:0] raw_real_i;
  logic        valid_o;
  logic [63:0] double_bits_o;

  logic [63:0] pending_doubles[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned gap_pct;
  bit          accepted_now;

  hex_real_to_ieee_double u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .raw_real_i    (raw_real_i),
    .valid_o       (valid_o),
    .double_bits_o (double_bits_o)
  );

  // Clock generation
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Compute the binary64 pattern of sign * frac/2^56 * 16^(hexexp-64)
  function automatic logic [63:0] to_double(input logic [63:0] raw);
    logic        sgn;
    logic [6:0]  hexexp;
    logic [55:0] frac;
    logic [55:0] rem_bits;
    logic [55:0] half_bit;
    logic [53:0] mant;
    int          lead;
    int          bin_exp;
    int          shift;
    sgn = raw[63];
    hexexp = raw[62:56];
    frac = raw[55:0];
    lead = 0;
    if (frac == '0) return {sgn, 63'd0};
    for (int k = 0; k < 56; k++) if (frac[k]) lead = k;
    bin_exp = lead + 4 * int'(hexexp) - 256 - 56;
    if (lead <= 52) begin
      mant = 54'(frac << (52 - lead));
    end else begin
      shift = lead - 52;
      rem_bits = frac & ((56'd1 << shift) - 56'd1);
      half_bit = 56'd1 << (shift - 1);
      mant = 54'(frac >> shift);
      if (rem_bits > half_bit || (rem_bits == half_bit && mant[0])) mant = mant + 54'd1;
      if (mant[53]) begin
        mant = mant >> 1;
        bin_exp++;
      end
    end
    return {sgn, 11'(bin_exp + 1023), mant[51:0]};
  endfunction

  // Check each result against the oldest prediction; watch for stalls
  always @(posedge clk_i) begin
    logic [63:0] want;
    accepted_now = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) accepted_now = 1'b1;
      if (valid_o) begin
        accepted_now = 1'b1;
        if (pending_doubles.size() == 0) begin
          $error("double_bits: unexpected result %h", double_bits_o);
          error_count++;
        end else begin
          want = pending_doubles.pop_front();
          if (double_bits_o !== want) begin
            $error("double_bits: expected %h actual %h", want, double_bits_o);
            error_count++;
          end
        end
      end
      idle_cycles = accepted_now ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("** hex_real_to_ieee_double: FAILED **");
        $finish;
      end
    end
  end

  // Send one item, with a random gap before it; start stays high until the
  // next gap, item or drain takes it over
  task automatic send_real(input logic [63:0] raw);
    while ($urandom_range(99, 0) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    raw_real_i <= raw;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_doubles.push_back(to_double(raw));
  endtask

  // Hold off until every expected result has arrived
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_doubles.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Field extremes, zeros, unnormalized fractions, rounding ties and carry
  task automatic test_directed();
    send_real(64'h0000_0000_0000_0000);
    send_real(64'h8000_0000_0000_0000);
    send_real(64'hFF00_0000_0000_0000);
    send_real(64'h4110_0000_0000_0000);
    send_real(64'hC110_0000_0000_0000);
    send_real(64'h7FFF_FFFF_FFFF_FFFF);
    send_real(64'hFFFF_FFFF_FFFF_FFFF);
    send_real(64'h0000_0000_0000_0001);
    send_real(64'h8000_0000_0000_0001);
    send_real(64'h0010_0000_0000_0000);
    send_real(64'h7F80_0000_0000_0000);
    send_real(64'h4100_0000_0000_0001);
    send_real(64'h4180_0000_0000_0004);
    send_real(64'h4180_0000_0000_000C);
    send_real(64'h4180_0000_0000_0008);
    send_real(64'h4180_0000_0000_0018);
    send_real(64'h4180_0000_0000_0009);
    send_real(64'h41FF_FFFF_FFFF_FFF8);
    send_real(64'h41FF_FFFF_FFFF_FFF7);
    send_real(64'h401F_FFFF_FFFF_FFFF);
    send_real(64'h4001_0000_0000_0000);
    send_real(64'h5555_5555_5555_5555);
    send_real(64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  // Random items with mixed fraction shapes
  task automatic test_random(input int unsigned count);
    logic [63:0] raw;
    for (int unsigned i = 0; i < count; i++) begin
      raw = rand64();
      case ($urandom_range(3, 0))
        0: raw[55:0] = raw[55:0] >> $urandom_range(55, 0);
        1: raw[3:0] = {$urandom_range(1, 0) ? 1'b1 : 1'b0, 3'b000};
        2: if ($urandom_range(7, 0) == 0) raw[55:0] = '0;
        default: ;
      endcase
      send_real(raw);
    end
  endtask

  initial begin
    error_count = 0;
    idle_cycles = 0;
    gap_pct     = 17;
    start_i     = 1'b0;
    raw_real_i  = '0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b0;
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(130);
    drain_results();
    gap_pct = 75;
    test_random(120);
    drain_results();
    gap_pct = 0;
    test_random(150);
    drain_results();
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** hex_real_to_ieee_double: PASSED **");
    end else begin
      $display("** hex_real_to_ieee_double: FAILED **");
    end
    $finish;
  end

endmodule
